// File: rtl/core/mfab_pkg.sv
// Shared types and constants for the mesh face adjacency builder.
`default_nettype none
package mfab_pkg;

  localparam int DEF_MAX_FACES   = 256;
  localparam int DEF_MAX_CORNERS = 8;
  localparam int VTX_W           = 10;
  localparam int NBR_W           = 9;
  localparam int IN_DATA_W       = 24;
  localparam int OUT_DATA_W      = 16;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_COMPUTE = 2'd1,
    REQ_READ    = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic load;
    logic clr;
    logic rd_req;
    logic rd_done;
    logic cmp_done;
    logic i_clr;
    logic i_inc;
    logic rd_size_i;
    logic n1_ld;
    logic e1_clr;
    logic e1_inc;
    logic rd_e1;
    logic v_ld;
    logic j_clr;
    logic j_inc;
    logic rd_size_j;
    logic n2_ld;
    logic e2_clr;
    logic e2_inc;
    logic wr_n1;
    logic wr_n2;
  } cmd_t;

  typedef struct packed {
    logic i_end;
    logic e1_end;
    logic j_end;
    logic j_is_i;
    logic e2_end;
    logic nbr_set;
    logic match;
    logic out_valid;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/core/mfab_datapath.sv
// Datapath: corner stores, face sizes, scan counters and output register.
`default_nettype none
module mfab_datapath import mfab_pkg::*; #(
  parameter int MAX_FACES   = DEF_MAX_FACES,
  parameter int MAX_CORNERS = DEF_MAX_CORNERS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  input  wire logic                  s_tlast,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  input  wire logic                  m_tready,
  output logic                       m_tvalid,
  output logic [1:0]                 m_tuser,
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  localparam int FA    = $clog2(MAX_FACES);
  localparam int FW    = $clog2(MAX_FACES + 1);
  localparam int CA    = $clog2(MAX_CORNERS);
  localparam int CW    = $clog2(MAX_CORNERS + 1);
  localparam int SA    = FA + CA;
  localparam int SLOTS = MAX_FACES << CA;
  localparam int NW    = (FA + 1 > NBR_W) ? FA + 1 : NBR_W;
  localparam int IW    = (FW > 8) ? FW : 8;
  localparam int KW    = (CW > 3) ? CW : 3;

  logic [VTX_W-1:0] vert_mem [SLOTS];
  logic [NW-1:0]    nbr_mem  [SLOTS];
  logic [CW-1:0]    size_mem [MAX_FACES];

  logic [FW-1:0]    face_total, i, j;
  logic [CW-1:0]    open_cnt, e1, e2, n1, n2;
  logic [VTX_W-1:0] v1, v2, vert_a_q, vert_b_q;
  logic [NW-1:0]    nbr_q;
  logic [CW-1:0]    size_q;
  logic [7:0]       fidx_q;
  logic [2:0]       cidx_q;
  logic [NBR_W-1:0] out_nbr;
  logic [1:0]       out_st;

  logic [VTX_W-1:0] vin;
  logic [7:0]       fin;
  logic [2:0]       cin;
  logic             ld_full, ld_room, ld_wr, range_bad;
  logic [CW-1:0]    open_after, e1_nx, e2_nx, e1_w, e2_w;
  logic [SA-1:0]    ld_addr, a_i_e1, a_i_w, a_j_e2, a_j_w, a_req;
  logic [FA-1:0]    size_addr;

  assign vin = s_tdata[9:0];
  assign fin = s_tdata[17:10];
  assign cin = s_tdata[20:18];

  assign ld_full    = face_total == FW'(MAX_FACES);
  assign ld_room    = open_cnt < CW'(MAX_CORNERS);
  assign ld_wr      = cmd.load && !ld_full && ld_room;
  assign open_after = ld_room ? open_cnt + 1'b1 : open_cnt;

  assign e1_nx = e1 + 1'b1;
  assign e2_nx = e2 + 1'b1;
  assign e1_w  = (e1_nx == n1) ? '0 : e1_nx;
  assign e2_w  = (e2_nx == n2) ? '0 : e2_nx;

  assign ld_addr = {face_total[FA-1:0], open_cnt[CA-1:0]};
  assign a_i_e1  = {i[FA-1:0], e1[CA-1:0]};
  assign a_i_w   = {i[FA-1:0], e1_w[CA-1:0]};
  assign a_j_e2  = {j[FA-1:0], e2[CA-1:0]};
  assign a_j_w   = {j[FA-1:0], e2_w[CA-1:0]};
  assign a_req   = {FA'(fin), CA'(cin)};
  assign size_addr = cmd.rd_size_i ? i[FA-1:0] : (cmd.rd_size_j ? j[FA-1:0] : FA'(fin));

  always_ff @(posedge clk) begin
    if (ld_wr) begin
      vert_mem[ld_addr] <= vin;
    end
    vert_a_q <= vert_mem[cmd.rd_e1 ? a_i_e1 : a_j_e2];
    vert_b_q <= vert_mem[cmd.rd_e1 ? a_i_w : a_j_w];
  end

  always_ff @(posedge clk) begin
    if (ld_wr) begin
      nbr_mem[ld_addr] <= '1;
    end else if (cmd.wr_n1) begin
      nbr_mem[a_i_e1] <= NW'(j);
    end else if (cmd.wr_n2) begin
      nbr_mem[a_j_e2] <= NW'(i);
    end
    nbr_q <= nbr_mem[cmd.rd_e1 ? a_i_e1 : a_req];
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !ld_full && s_tlast) begin
      size_mem[face_total[FA-1:0]] <= open_after;
    end
    size_q <= size_mem[size_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      face_total <= '0;
      open_cnt   <= '0;
    end else if (cmd.clr) begin
      face_total <= '0;
      open_cnt   <= '0;
    end else if (cmd.load && !ld_full) begin
      if (s_tlast) begin
        face_total <= face_total + 1'b1;
        open_cnt   <= '0;
      end else begin
        open_cnt <= open_after;
      end
    end
  end

  // scan counters and captured edge
  always_ff @(posedge clk) begin
    if (cmd.i_clr) i <= '0;
    else if (cmd.i_inc) i <= i + 1'b1;
    if (cmd.j_clr) j <= '0;
    else if (cmd.j_inc) j <= j + 1'b1;
    if (cmd.e1_clr) e1 <= '0;
    else if (cmd.e1_inc) e1 <= e1_nx;
    if (cmd.e2_clr) e2 <= '0;
    else if (cmd.e2_inc) e2 <= e2_nx;
    if (cmd.n1_ld) n1 <= size_q;
    if (cmd.n2_ld) n2 <= size_q;
    if (cmd.v_ld) begin
      v1 <= vert_a_q;
      v2 <= vert_b_q;
    end
    if (cmd.rd_req) begin
      fidx_q <= fin;
      cidx_q <= cin;
    end
  end

  assign range_bad = (IW'(fidx_q) >= IW'(face_total)) || (KW'(cidx_q) >= KW'(size_q));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load || cmd.clr || cmd.cmp_done || cmd.rd_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_st  <= (ld_full || !ld_room) ? ST_OVF : ST_OK;
      out_nbr <= '1;
    end else if (cmd.rd_done) begin
      out_st  <= range_bad ? ST_RANGE : ST_OK;
      out_nbr <= range_bad ? '1 : NBR_W'(nbr_q);
    end else if (cmd.clr || cmd.cmp_done) begin
      out_st  <= ST_OK;
      out_nbr <= '1;
    end
  end

  assign m_tuser = out_st;
  assign m_tdata = OUT_DATA_W'(out_nbr);

  assign sts.i_end     = i == face_total;
  assign sts.e1_end    = e1 == n1;
  assign sts.j_end     = j == face_total;
  assign sts.j_is_i    = j == i;
  assign sts.e2_end    = e2 == n2;
  assign sts.nbr_set   = !nbr_q[NW-1];
  assign sts.match     = (v1 == vert_b_q) && (v2 == vert_a_q);
  assign sts.out_valid = m_tvalid;

endmodule
`default_nettype wire

// File: rtl/core/mfab_ctrl.sv
// Controller: request decode and the face-pair scan sequencer.
`default_nettype none
module mfab_ctrl import mfab_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  input  wire logic [1:0] s_tuser,
  output logic            s_tready,
  input  wire logic       m_tready,
  input  wire sts_t       sts,
  output cmd_t            cmd
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_RD   = 11'b00000000010,
    S_CI   = 11'b00000000100,
    S_CIW  = 11'b00000001000,
    S_CE1  = 11'b00000010000,
    S_CE1W = 11'b00000100000,
    S_CJ   = 11'b00001000000,
    S_CJW  = 11'b00010000000,
    S_CE2  = 11'b00100000000,
    S_CE2W = 11'b01000000000,
    S_CWR2 = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign s_tready = (state == S_IDLE) && !(sts.out_valid && !m_tready);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (s_tuser)
            REQ_LOAD:    cmd.load = 1'b1;
            REQ_CLEAR:   cmd.clr  = 1'b1;
            REQ_READ: begin
              cmd.rd_req = 1'b1;
              state_next = S_RD;
            end
            default: begin
              cmd.i_clr  = 1'b1;
              state_next = S_CI;
            end
          endcase
        end
      end
      S_RD: begin
        cmd.rd_done = 1'b1;
        state_next  = S_IDLE;
      end
      S_CI: begin
        if (sts.i_end) begin
          cmd.cmp_done = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.rd_size_i = 1'b1;
          state_next    = S_CIW;
        end
      end
      S_CIW: begin
        cmd.n1_ld  = 1'b1;
        cmd.e1_clr = 1'b1;
        state_next = S_CE1;
      end
      S_CE1: begin
        if (sts.e1_end) begin
          cmd.i_inc  = 1'b1;
          state_next = S_CI;
        end else begin
          cmd.rd_e1  = 1'b1;
          state_next = S_CE1W;
        end
      end
      S_CE1W: begin
        if (sts.nbr_set) begin
          cmd.e1_inc = 1'b1;
          state_next = S_CE1;
        end else begin
          cmd.v_ld   = 1'b1;
          cmd.j_clr  = 1'b1;
          state_next = S_CJ;
        end
      end
      S_CJ: begin
        if (sts.j_end) begin
          cmd.e1_inc = 1'b1;
          state_next = S_CE1;
        end else if (sts.j_is_i) begin
          cmd.j_inc = 1'b1;
        end else begin
          cmd.rd_size_j = 1'b1;
          state_next    = S_CJW;
        end
      end
      S_CJW: begin
        cmd.n2_ld  = 1'b1;
        cmd.e2_clr = 1'b1;
        state_next = S_CE2;
      end
      S_CE2: begin
        if (sts.e2_end) begin
          cmd.j_inc  = 1'b1;
          state_next = S_CJ;
        end else begin
          state_next = S_CE2W;
        end
      end
      S_CE2W: begin
        if (sts.match) begin
          cmd.wr_n1  = 1'b1;
          state_next = S_CWR2;
        end else begin
          cmd.e2_inc = 1'b1;
          state_next = S_CE2;
        end
      end
      S_CWR2: begin
        cmd.wr_n2  = 1'b1;
        cmd.j_inc  = 1'b1;
        state_next = S_CJ;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/mesh_face_adjacency_builder_top.sv
// Top level of the mesh face adjacency builder.
// Faces are loaded one corner per beat and closed by tlast; each request returns one
// result beat. Load and clear sustain one beat per cycle while the result is not
// stalled; a read passes through the registered neighbor and face size memories and
// then the output register. A compute request holds tready low while the sequencer
// walks every face i, every unmatched edge of it, and every other face j edge by
// edge, comparing each edge through the vertex memory read ports. Stores need no
// clearing pass after reset.
`default_nettype none
module mesh_face_adjacency_builder_top import mfab_pkg::*; #(
  parameter int MAX_FACES   = DEF_MAX_FACES,
  parameter int MAX_CORNERS = DEF_MAX_CORNERS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,  // vertex_index, face_index, corner_index
  input  wire logic [1:0]            s_tuser,  // req_type
  input  wire logic                  s_tlast,  // end_of_face
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,  // adj_face (unsigned, 511 with the low 9 bits all ones for boundary)
  output logic [1:0]                 m_tuser   // status
);

  cmd_t cmd;
  sts_t sts;

  mfab_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mfab_datapath #(
    .MAX_FACES   (MAX_FACES),
    .MAX_CORNERS (MAX_CORNERS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .cmd      (cmd),
    .sts      (sts),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

  // never take a beat while a result is stuck
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !(m_tvalid && !m_tready)) else $error("input taken over stalled result");

  // compute holds the input side
  a_cmp_block: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == REQ_COMPUTE) |=> !s_tready)
    else $error("input taken during compute");

  // read result follows the request through the S_RD state and the output register
  a_rd_lat: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == REQ_READ) |=> ##1 m_tvalid)
    else $error("read result missing");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_OVF || m_tuser == ST_RANGE))
    else $error("bad status code");

endmodule
`default_nettype wire
